// ----- src/sfb_pkg.sv -----
// ============================================================================
// sfb_pkg - span fill blit address generator shared definitions
// Field widths, beat packing, register indexes and the result beat type.
// ============================================================================
`default_nettype none

package sfb_pkg;

   // Block constants
   localparam int ADDR_BITS          = 24;
   localparam int MAX_CHUNKS         = 64;
   localparam int PATTERN_ROW_STRIDE = 8;

   // Field widths
   localparam int X_W      = 12;
   localparam int Y_W      = 12;
   localparam int SPAN_W   = 11;
   localparam int MODE_W   = 2;
   localparam int STRIDE_W = 13;
   localparam int TILE_W   = 11;
   localparam int ORG_W    = 12;
   localparam int CURSOR_W = 13;
   localparam int PROD_W   = Y_W + STRIDE_W;
   localparam int LIMIT_W  = TILE_W + $clog2(MAX_CHUNKS) + 1;

   // Remainder unit: one quotient bit per step over the dividend width
   localparam int MOD_STEPS  = CURSOR_W;
   localparam int STEP_W     = $clog2(MOD_STEPS);
   localparam int SHIFT_W    = TILE_W + MOD_STEPS - 1;

   // Beat packing
   localparam int REQ_FIELDS_W = X_W + Y_W + SPAN_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * ADDR_BITS + SPAN_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Bit positions in rsp_tdata
   localparam int RSP_DST_LSB   = ADDR_BITS;
   localparam int RSP_WIDTH_LSB = 2 * ADDR_BITS;
   localparam int RSP_BEND_BIT  = 2 * ADDR_BITS + SPAN_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = ADDR_BITS;

   localparam logic [CSR_INDEX_W-1:0] REG_FILL_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_STRIDE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TILE_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_ORG_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_ORG_Y = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TILE_BASE     = 3'd6;

   // Fill modes
   localparam logic [MODE_W-1:0] MODE_SOLID     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OFFSCREEN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PATTERN   = 2'd2;

   // One result beat
   typedef struct packed {
      logic                 error;
      logic                 batch_end;
      logic                 chunk_last;
      logic [SPAN_W-1:0]    chunk_width;
      logic [ADDR_BITS-1:0] dst_addr;
      logic [ADDR_BITS-1:0] src_addr;
   } chunk_type;

endpackage

`default_nettype wire

// ----- src/span_fill_blit_address_generator.sv -----
// ============================================================================
// span_fill_blit_address_generator - blitter command generator for spans
// Turns one span (x, y, width) into pattern source / destination chunks.
// ============================================================================
// One span is taken at a time. After the request beat is accepted, a shared
// shift-and-subtract remainder unit finds the tile phase in four passes of
// 13 steps each, one multiplier then forms the row and source row offsets
// and the addresses, and the chunks follow at one beat per cycle while
// rsp_tready is high. A span gives one chunk in solid and cached pattern
// modes and up to 64 in offscreen tile mode. The last chunk sits in the output
// register while the next request is accepted. Configuration writes are
// always ready and are meant to be issued only while the block is idle.
`default_nettype none

module span_fill_blit_address_generator (
   input  wire                                   clock,
   input  wire                                   reset,
   // request: span_x, span_y, span_width, zero pad (lowest bit up)
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [sfb_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire                                   req_tlast,
   // response: src_addr, dst_addr, chunk_width, batch_end, zero pad
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [sfb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast,
   // response tuser: error
   output logic                                  rsp_tuser,
   // configuration write channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [sfb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [sfb_pkg::CSR_DATA_W-1:0]        csr_data
);
   import sfb_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MOD     = 3'd1;
   localparam logic [2:0] ST_MUL_ROW = 3'd2;
   localparam logic [2:0] ST_MUL_SRC = 3'd3;
   localparam logic [2:0] ST_ADDR    = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;

   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(MOD_STEPS - 1);

   // Configuration registers
   logic [MODE_W-1:0]    fill_mode_ff;
   logic [STRIDE_W-1:0]  line_stride_ff;
   logic [TILE_W-1:0]    tile_width_ff;
   logic [TILE_W-1:0]    tile_height_ff;
   logic [ORG_W-1:0]     org_x_ff;
   logic [ORG_W-1:0]     org_y_ff;
   logic [ADDR_BITS-1:0] tile_base_ff;

   // Sequencer and span state
   logic [2:0]           state_ff, state_in;
   logic [X_W-1:0]       x_ff;
   logic [Y_W-1:0]       y_ff;
   logic [SPAN_W-1:0]    w_ff;
   logic                 bl_ff;
   logic [CURSOR_W-1:0]  rem_ff, rem_in;
   logic [TILE_W-1:0]    div_ff, div_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [1:0]           op_ff, op_in;
   logic [TILE_W-1:0]    srcx_ff, srcx_in;
   logic [TILE_W-1:0]    srcy_ff, srcy_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ADDR_BITS-1:0] row_ff, row_in;
   logic [ADDR_BITS-1:0] src_ff, src_in;
   logic                 err_ff, err_in;
   logic                 single_ff, single_in;
   logic [CURSOR_W-1:0]  cursor_ff, cursor_in;
   logic [SPAN_W-1:0]    left_ff, left_in;

   // Output register
   logic                 out_valid_ff, out_valid_in;
   chunk_type            out_ff, out_in;

   // Datapath wires
   logic [TILE_W-1:0]    tw, th;
   logic [SHIFT_W-1:0]   shifted;
   logic                 ge;
   logic [CURSOR_W-1:0]  rem_next;
   logic [Y_W-1:0]       mul_a;
   logic [PROD_W-1:0]    product;
   logic [LIMIT_W-1:0]   chunk_limit;
   logic [SPAN_W-1:0]    dx;
   logic                 dx_last;
   logic [ADDR_BITS-1:0] dst_now;
   logic                 out_free;
   logic                 req_fire;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   // Zero tile size is taken as one
   assign tw = (tile_width_ff == '0) ? TILE_W'(1) : tile_width_ff;
   assign th = (tile_height_ff == '0) ? TILE_W'(1) : tile_height_ff;

   // Shared remainder step: subtract divisor shifted by the current step
   assign shifted  = SHIFT_W'(div_ff) << step_ff;
   assign ge       = SHIFT_W'(rem_ff) >= shifted;
   assign rem_next = ge ? (rem_ff - shifted[CURSOR_W-1:0]) : rem_ff;

   // Shared multiplier: row offset first, then the pattern row offset
   assign mul_a   = (state_ff == ST_MUL_ROW) ? y_ff : Y_W'(srcy_ff);
   assign product = PROD_W'(mul_a) * PROD_W'(line_stride_ff);

   // Chunk count check: more than MAX_CHUNKS chunks iff width > tw * MAX_CHUNKS
   assign chunk_limit = LIMIT_W'(tw) * LIMIT_W'(MAX_CHUNKS);

   // Chunk split
   assign dx      = (left_ff > tw) ? tw : left_ff;
   assign dx_last = (dx == left_ff);
   assign dst_now = row_ff + ADDR_BITS'(cursor_ff);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      srcx_in      = srcx_ff;
      srcy_in      = srcy_ff;
      prod_in      = prod_ff;
      row_in       = row_ff;
      src_in       = src_ff;
      err_in       = err_ff;
      single_in    = single_ff;
      cursor_in    = cursor_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rem_in   = CURSOR_W'(org_x_ff);
               div_in   = tw;
               step_in  = STEP_TOP;
               op_in    = 2'd0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in = rem_next;
            if (step_ff != '0) begin
               step_in = step_ff - STEP_W'(1);
            end else begin
               step_in = STEP_TOP;
               op_in   = op_ff + 2'd1;
               case (op_ff)
                  2'd0: rem_in = CURSOR_W'(tw - rem_next[TILE_W-1:0]) + CURSOR_W'(x_ff);
                  2'd1: begin
                     srcx_in = rem_next[TILE_W-1:0];
                     rem_in  = CURSOR_W'(org_y_ff);
                     div_in  = th;
                  end
                  2'd2: rem_in = CURSOR_W'(th - rem_next[TILE_W-1:0]) + CURSOR_W'(y_ff);
                  default: begin
                     srcy_in  = rem_next[TILE_W-1:0];
                     state_in = ST_MUL_ROW;
                  end
               endcase
            end
         end
         ST_MUL_ROW: begin
            prod_in  = product;
            state_in = ST_MUL_SRC;
         end
         ST_MUL_SRC: begin
            row_in   = prod_ff[ADDR_BITS-1:0];
            prod_in  = product;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            case (fill_mode_ff)
               MODE_OFFSCREEN:
                  src_in = tile_base_ff + prod_ff[ADDR_BITS-1:0] + ADDR_BITS'(srcx_ff);
               MODE_PATTERN:
                  src_in = tile_base_ff
                         + ADDR_BITS'(srcy_ff) * ADDR_BITS'(PATTERN_ROW_STRIDE)
                         + ADDR_BITS'(srcx_ff);
               default: src_in = '0;
            endcase
            err_in    = (fill_mode_ff == MODE_OFFSCREEN) && (LIMIT_W'(w_ff) > chunk_limit);
            single_in = (fill_mode_ff != MODE_OFFSCREEN) || err_in || (w_ff == '0);
            cursor_in = CURSOR_W'(x_ff);
            left_in   = w_ff;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (single_ff) begin
                  out_in.src_addr    = err_ff ? '0 : src_ff;
                  out_in.dst_addr    = dst_now;
                  out_in.chunk_width = err_ff ? '0 : w_ff;
                  out_in.chunk_last  = 1'b1;
                  out_in.batch_end   = bl_ff;
                  out_in.error       = err_ff;
                  state_in           = ST_IDLE;
               end else begin
                  out_in.src_addr    = src_ff;
                  out_in.dst_addr    = dst_now;
                  out_in.chunk_width = dx;
                  out_in.chunk_last  = dx_last;
                  out_in.batch_end   = dx_last && bl_ff;
                  out_in.error       = 1'b0;
                  cursor_in          = cursor_ff + CURSOR_W'(dx);
                  left_in            = left_ff - dx;
                  if (dx_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff  <= req_tdata[X_W-1:0];
         y_ff  <= req_tdata[X_W+Y_W-1:X_W];
         w_ff  <= req_tdata[REQ_FIELDS_W-1:X_W+Y_W];
         bl_ff <= req_tlast;
      end
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      step_ff   <= step_in;
      op_ff     <= op_in;
      srcx_ff   <= srcx_in;
      srcy_ff   <= srcy_in;
      prod_ff   <= prod_in;
      row_ff    <= row_in;
      src_ff    <= src_in;
      err_ff    <= err_in;
      single_ff <= single_in;
      cursor_ff <= cursor_in;
      left_ff   <= left_in;
      out_ff    <= out_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff   <= MODE_SOLID;
         line_stride_ff <= STRIDE_W'(1024);
         tile_width_ff  <= TILE_W'(8);
         tile_height_ff <= TILE_W'(8);
         org_x_ff       <= '0;
         org_y_ff       <= '0;
         tile_base_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FILL_MODE:     fill_mode_ff   <= csr_data[MODE_W-1:0];
            REG_LINE_STRIDE:   line_stride_ff <= csr_data[STRIDE_W-1:0];
            REG_TILE_WIDTH:    tile_width_ff  <= csr_data[TILE_W-1:0];
            REG_TILE_HEIGHT:   tile_height_ff <= csr_data[TILE_W-1:0];
            REG_PATTERN_ORG_X: org_x_ff       <= csr_data[ORG_W-1:0];
            REG_PATTERN_ORG_Y: org_y_ff       <= csr_data[ORG_W-1:0];
            REG_TILE_BASE:     tile_base_ff   <= csr_data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.chunk_last;
   assign rsp_tuser  = out_ff.error;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.batch_end, out_ff.chunk_width,
                                    out_ff.dst_addr, out_ff.src_addr});

endmodule

`default_nettype wire

// ----- src/sfb_checker.sv -----
// ============================================================================
// sfb_checker - port checks for the span fill blit address generator
// Watches the top-level ports and flags beats that break the chunk rules.
// ============================================================================
`default_nettype none

module sfb_checker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   input  wire                                   req_tready,
   input  wire                                   rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire  [sfb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire                                   rsp_tlast,
   input  wire                                   rsp_tuser
);
   import sfb_pkg::*;

   logic [SPAN_W-1:0] chunk_width;
   logic              batch_end;

   assign chunk_width = rsp_tdata[RSP_WIDTH_LSB+SPAN_W-1:RSP_WIDTH_LSB];
   assign batch_end   = rsp_tdata[RSP_BEND_BIT];

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // One span at a time: no request right after an accepted one
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a span is in work");

   // Error beat closes the span with no pixels
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (chunk_width == '0))
      else $error("error beat not a lone empty last chunk");

   // Request end only on the last chunk of a span
   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && batch_end |-> rsp_tlast)
      else $error("batch end on a chunk that is not last");

   // Chunks ahead of the last one carry pixels and no error
   a_mid_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (chunk_width != '0) && !rsp_tuser)
      else $error("empty or failed chunk in the middle of a span");

endmodule

bind span_fill_blit_address_generator sfb_checker u_sfb_checker (.*);

`default_nettype wire
